// ===== rtl/ocu_pkg.sv =====
`default_nettype none

package ocu_pkg;

   // iteration count of the sine/cosine unit
   localparam int CORDIC_STEPS    = 16;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int CORDIC_N        = (CORDIC_STEPS > ANGLE_TABLE_LEN) ?
                                    ANGLE_TABLE_LEN : CORDIC_STEPS;
   localparam int ITER_W          = $clog2(CORDIC_N);

   // datapath widths
   localparam int XY_W = 32;   // cordic x/y, Q2.30
   localparam int Z_W  = 26;   // cordic residual angle, Q16 degrees

   // angle and radius constants, 1/256 degree and Q.16
   localparam int FULL_TURN        = 92160;
   localparam int HALF_TURN        = 46080;
   localparam int QUARTER_TURN     = 23040;
   localparam int ELEV_CAP         = 23039;
   localparam int RADIUS_MAX       = 268435455;
   localparam int RADIUS_RESET     = 327680;
   localparam int GAIN_Q30         = 652032874;
   localparam int ELEV_LIMIT_RESET = 23014;
   localparam int MIN_RADIUS_RESET = 6554;

   // request operations
   localparam logic [1:0] OP_ROTATE = 2'd0;
   localparam logic [1:0] OP_ZOOM   = 2'd1;
   localparam logic [1:0] OP_SET    = 2'd2;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEV_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RADIUS = 2'd1;

   // microprogram
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
   localparam logic [PC_W-1:0] PC_AZ_LOOP = 5'd6;
   localparam logic [PC_W-1:0] PC_EL_LOOP = 5'd9;

   typedef enum logic [4:0] {
      ACT_NOP,
      ACT_IDLE,
      ACT_LOAD,
      ACT_FIX,
      ACT_COMMIT,
      ACT_START_AZ,
      ACT_START_EL,
      ACT_ITER,
      ACT_SAVE_AZ,
      ACT_SAVE_EL,
      ACT_MUL_CE_SA,
      ACT_MUL_CE_CA,
      ACT_MUL_R_SE,
      ACT_MUL_SE_SA,
      ACT_MUL_SE_CA,
      ACT_MUL_R_P1,
      ACT_MUL_R_P2,
      ACT_EMIT
   } act_type;

   typedef enum logic [2:0] {
      BR_NEXT,
      BR_JUMP,
      BR_LOOP,
      BR_WAIT_REQ,
      BR_WAIT_OUT
   } br_type;

   typedef struct packed {
      act_type         act;
      br_type          br;
      logic [PC_W-1:0] target;
   } ctrl_type;

   typedef struct packed {
      logic req_fire;
      logic out_free;
      logic iter_last;
   } stat_type;

   // atan(2^-i) in Q16 degrees
   function automatic logic [21:0] atan_q16(input logic [4:0] idx);
      logic [21:0] v;
      unique case (idx)
         5'd0:    v = 22'd2949120;
         5'd1:    v = 22'd1740967;
         5'd2:    v = 22'd919879;
         5'd3:    v = 22'd466945;
         5'd4:    v = 22'd234379;
         5'd5:    v = 22'd117304;
         5'd6:    v = 22'd58666;
         5'd7:    v = 22'd29335;
         5'd8:    v = 22'd14668;
         5'd9:    v = 22'd7334;
         5'd10:   v = 22'd3667;
         5'd11:   v = 22'd1833;
         5'd12:   v = 22'd917;
         5'd13:   v = 22'd458;
         5'd14:   v = 22'd229;
         5'd15:   v = 22'd115;
         5'd16:   v = 22'd57;
         5'd17:   v = 22'd29;
         5'd18:   v = 22'd14;
         5'd19:   v = 22'd7;
         5'd20:   v = 22'd4;
         5'd21:   v = 22'd2;
         5'd22:   v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

   // control store
   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type cw;
      unique case (pc)
         5'd0:    cw = '{ACT_IDLE,      BR_WAIT_REQ, PC_IDLE};
         5'd1:    cw = '{ACT_LOAD,      BR_NEXT,     PC_IDLE};
         5'd2:    cw = '{ACT_FIX,       BR_NEXT,     PC_IDLE};
         5'd3:    cw = '{ACT_FIX,       BR_NEXT,     PC_IDLE};
         5'd4:    cw = '{ACT_COMMIT,    BR_NEXT,     PC_IDLE};
         5'd5:    cw = '{ACT_START_AZ,  BR_NEXT,     PC_IDLE};
         5'd6:    cw = '{ACT_ITER,      BR_LOOP,     PC_AZ_LOOP};
         5'd7:    cw = '{ACT_SAVE_AZ,   BR_NEXT,     PC_IDLE};
         5'd8:    cw = '{ACT_START_EL,  BR_NEXT,     PC_IDLE};
         5'd9:    cw = '{ACT_ITER,      BR_LOOP,     PC_EL_LOOP};
         5'd10:   cw = '{ACT_SAVE_EL,   BR_NEXT,     PC_IDLE};
         5'd11:   cw = '{ACT_MUL_CE_SA, BR_NEXT,     PC_IDLE};
         5'd12:   cw = '{ACT_MUL_CE_CA, BR_NEXT,     PC_IDLE};
         5'd13:   cw = '{ACT_MUL_R_SE,  BR_NEXT,     PC_IDLE};
         5'd14:   cw = '{ACT_MUL_SE_SA, BR_NEXT,     PC_IDLE};
         5'd15:   cw = '{ACT_MUL_SE_CA, BR_NEXT,     PC_IDLE};
         5'd16:   cw = '{ACT_MUL_R_P1,  BR_NEXT,     PC_IDLE};
         5'd17:   cw = '{ACT_MUL_R_P2,  BR_NEXT,     PC_IDLE};
         5'd18:   cw = '{ACT_EMIT,      BR_WAIT_OUT, PC_IDLE};
         default: cw = '{ACT_NOP,       BR_JUMP,     PC_IDLE};
      endcase
      return cw;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ocu_seq.sv =====
`default_nettype none

module ocu_seq (
   input  logic              clock,
   input  logic              reset,
   input  ocu_pkg::stat_type stat,
   output ocu_pkg::ctrl_type ctrl
);

   logic [ocu_pkg::PC_W-1:0] pc_ff;
   logic [ocu_pkg::PC_W-1:0] pc_in;
   ocu_pkg::ctrl_type        cw;

   always_comb begin
      cw = ocu_pkg::ucode(pc_ff);
   end

   always_comb begin
      unique case (cw.br)
         ocu_pkg::BR_NEXT:     pc_in = pc_ff + ocu_pkg::PC_W'(1);
         ocu_pkg::BR_JUMP:     pc_in = cw.target;
         ocu_pkg::BR_LOOP:     pc_in = stat.iter_last ? pc_ff + ocu_pkg::PC_W'(1) : cw.target;
         ocu_pkg::BR_WAIT_REQ: pc_in = stat.req_fire ? pc_ff + ocu_pkg::PC_W'(1) : pc_ff;
         ocu_pkg::BR_WAIT_OUT: pc_in = stat.out_free ? cw.target : pc_ff;
         default:              pc_in = ocu_pkg::PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ocu_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign ctrl = cw;

endmodule

`default_nettype wire

// ===== rtl/ocu_cordic.sv =====
`default_nettype none

module ocu_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               step,
   input  logic signed [17:0] angle,
   output logic signed [15:0] sin_q15,
   output logic signed [15:0] cos_q15,
   output logic               last
);

   logic signed [ocu_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in, x_sh, y_sh;
   logic signed [ocu_pkg::Z_W-1:0]  z_ff, z_in, z_start, atan_z;
   logic [ocu_pkg::ITER_W-1:0]      iter_ff, iter_in;
   logic                            flip_ff, flip_in, flip_start;
   logic signed [17:0]              a_half, a_quad;

   // Q2.30 to Q1.15 with round half up, clamp, optional negate
   function automatic logic signed [15:0] to_q15(input logic signed [ocu_pkg::XY_W-1:0] v,
                                                 input logic neg);
      logic signed [ocu_pkg::XY_W:0]    t;
      logic signed [ocu_pkg::XY_W-15:0] q;
      logic signed [15:0]               c;
      t = (ocu_pkg::XY_W+1)'(v) + (ocu_pkg::XY_W+1)'(16384);
      q = t[ocu_pkg::XY_W:15];
      if (q > (ocu_pkg::XY_W-14)'(32767)) begin
         q = (ocu_pkg::XY_W-14)'(32767);
      end else if (q < (ocu_pkg::XY_W-14)'(-32767)) begin
         q = (ocu_pkg::XY_W-14)'(-32767);
      end
      c = q[15:0];
      if (neg) begin
         c = -c;
      end
      return c;
   endfunction

   // fold the angle into [-90, 90] degrees, remembering a half-turn flip
   always_comb begin
      a_half = angle;
      if (angle > 18'(ocu_pkg::HALF_TURN)) begin
         a_half = angle - 18'(ocu_pkg::FULL_TURN);
      end else if (angle <= -18'(ocu_pkg::HALF_TURN)) begin
         a_half = angle + 18'(ocu_pkg::FULL_TURN);
      end
      a_quad     = a_half;
      flip_start = 1'b0;
      if (a_half > 18'(ocu_pkg::QUARTER_TURN)) begin
         a_quad     = a_half - 18'(ocu_pkg::HALF_TURN);
         flip_start = 1'b1;
      end else if (a_half < -18'(ocu_pkg::QUARTER_TURN)) begin
         a_quad     = a_half + 18'(ocu_pkg::HALF_TURN);
         flip_start = 1'b1;
      end
      z_start = ocu_pkg::Z_W'(a_quad) <<< 8;
   end

   assign x_sh   = x_ff >>> iter_ff;
   assign y_sh   = y_ff >>> iter_ff;
   assign atan_z = signed'(ocu_pkg::Z_W'(ocu_pkg::atan_q16(5'(iter_ff))));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      if (start) begin
         x_in    = ocu_pkg::XY_W'(ocu_pkg::GAIN_Q30);
         y_in    = '0;
         z_in    = z_start;
         flip_in = flip_start;
         iter_in = '0;
      end else if (step) begin
         if (!z_ff[ocu_pkg::Z_W-1]) begin
            x_in = x_ff - y_sh;
            y_in = y_ff + x_sh;
            z_in = z_ff - atan_z;
         end else begin
            x_in = x_ff + y_sh;
            y_in = y_ff - x_sh;
            z_in = z_ff + atan_z;
         end
         iter_in = iter_ff + ocu_pkg::ITER_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
   end

   assign last    = (iter_ff == ocu_pkg::ITER_W'(ocu_pkg::CORDIC_N - 1));
   assign sin_q15 = to_q15(y_ff, flip_ff);
   assign cos_q15 = to_q15(x_ff, flip_ff);

endmodule

`default_nettype wire

// ===== rtl/ocu_dpath.sv =====
`default_nettype none

module ocu_dpath (
   input  logic               clock,
   input  logic               reset,
   input  ocu_pkg::ctrl_type  ctrl,
   input  logic [1:0]         op,
   input  logic signed [17:0] az_value,
   input  logic signed [17:0] el_value,
   input  logic signed [28:0] rad_delta,
   input  logic [14:0]        elev_lim,
   input  logic [15:0]        min_rad,
   input  logic signed [15:0] cor_sin,
   input  logic signed [15:0] cor_cos,
   output logic signed [17:0] cor_angle,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [28:0] rsp_position_x,
   output logic signed [28:0] rsp_position_y,
   output logic signed [28:0] rsp_position_z,
   output logic signed [15:0] rsp_right_x,
   output logic               rsp_right_y,
   output logic signed [15:0] rsp_right_z,
   output logic signed [15:0] rsp_up_x,
   output logic signed [15:0] rsp_up_y,
   output logic signed [15:0] rsp_up_z,
   output logic [16:0]        rsp_azimuth_now,
   output logic signed [15:0] rsp_elevation_now,
   output logic [27:0]        rsp_radius_now
);

   // camera state
   logic [16:0]        az_ff, az_in;
   logic signed [15:0] el_ff, el_in;
   logic [27:0]        rad_ff, rad_in;
   // update scratch
   logic signed [18:0] taz_ff, taz_in, tel_ff, tel_in;
   logic signed [30:0] trad_ff, trad_in;
   // sines and cosines
   logic signed [15:0] sa_ff, sa_in, ca_ff, ca_in, se_ff, se_in, ce_ff, ce_in;
   // products
   logic signed [31:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [58:0]        pxp_ff, pxp_in, pzp_ff, pzp_in;
   logic [43:0]        pyp_ff, pyp_in;
   logic [30:0]        uxp_ff, uxp_in, uzp_ff, uzp_in;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   // limits
   logic signed [18:0] lim19, full19;
   logic signed [30:0] minr31, rmax31;
   // result
   logic               rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [58:0]        px_sum, pz_sum;
   logic [43:0]        py_sum;
   logic [30:0]        ux_sum, uz_sum;
   logic signed [28:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] right_x_ff, right_z_ff, up_x_ff, up_y_ff, up_z_ff;
   logic [16:0]        az_now_ff;
   logic signed [15:0] el_now_ff;
   logic [27:0]        rad_now_ff;

   assign lim19  = signed'({4'b0000, elev_lim});
   assign full19 = 19'(ocu_pkg::FULL_TURN);
   assign minr31 = signed'({15'b0, min_rad});
   assign rmax31 = 31'(ocu_pkg::RADIUS_MAX);

   // shared 32x32 signed multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (ctrl.act)
         ocu_pkg::ACT_MUL_CE_SA: begin
            mul_a = 32'(ce_ff);
            mul_b = 32'(sa_ff);
         end
         ocu_pkg::ACT_MUL_CE_CA: begin
            mul_a = 32'(ce_ff);
            mul_b = 32'(ca_ff);
         end
         ocu_pkg::ACT_MUL_R_SE: begin
            mul_a = signed'({4'b0000, rad_ff});
            mul_b = 32'(se_ff);
         end
         ocu_pkg::ACT_MUL_SE_SA: begin
            mul_a = 32'(se_ff);
            mul_b = 32'(sa_ff);
         end
         ocu_pkg::ACT_MUL_SE_CA: begin
            mul_a = 32'(se_ff);
            mul_b = 32'(ca_ff);
         end
         ocu_pkg::ACT_MUL_R_P1: begin
            mul_a = signed'({4'b0000, rad_ff});
            mul_b = p1_ff;
         end
         ocu_pkg::ACT_MUL_R_P2: begin
            mul_a = signed'({4'b0000, rad_ff});
            mul_b = p2_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      az_in   = az_ff;
      el_in   = el_ff;
      rad_in  = rad_ff;
      taz_in  = taz_ff;
      tel_in  = tel_ff;
      trad_in = trad_ff;
      sa_in   = sa_ff;
      ca_in   = ca_ff;
      se_in   = se_ff;
      ce_in   = ce_ff;
      p1_in   = p1_ff;
      p2_in   = p2_ff;
      pxp_in  = pxp_ff;
      pyp_in  = pyp_ff;
      pzp_in  = pzp_ff;
      uxp_in  = uxp_ff;
      uzp_in  = uzp_ff;
      case (ctrl.act)
         ocu_pkg::ACT_LOAD: begin
            if (op == ocu_pkg::OP_ROTATE) begin
               taz_in = signed'({2'b00, az_ff}) + 19'(az_value);
               tel_in = 19'(el_ff) + 19'(el_value);
            end else begin
               taz_in = 19'(az_value);
               tel_in = 19'(el_value);
            end
            trad_in = signed'({3'b000, rad_ff}) - 31'(rad_delta);
         end
         ocu_pkg::ACT_FIX: begin
            // one wrap correction per pass, clamps settle on the first
            if (taz_ff < 0) begin
               taz_in = taz_ff + full19;
            end else if (taz_ff >= full19) begin
               taz_in = taz_ff - full19;
            end
            if (tel_ff > lim19) begin
               tel_in = lim19;
            end else if (tel_ff < -lim19) begin
               tel_in = -lim19;
            end
            if (trad_ff < minr31) begin
               trad_in = minr31;
            end else if (trad_ff > rmax31) begin
               trad_in = rmax31;
            end
         end
         ocu_pkg::ACT_COMMIT: begin
            case (op) inside
               ocu_pkg::OP_ROTATE, ocu_pkg::OP_SET: begin
                  az_in = taz_ff[16:0];
                  el_in = tel_ff[15:0];
               end
               ocu_pkg::OP_ZOOM: begin
                  rad_in = trad_ff[27:0];
               end
               default: begin
                  rad_in = rad_ff;
               end
            endcase
         end
         ocu_pkg::ACT_SAVE_AZ: begin
            sa_in = cor_sin;
            ca_in = cor_cos;
         end
         ocu_pkg::ACT_SAVE_EL: begin
            se_in = cor_sin;
            ce_in = cor_cos;
         end
         ocu_pkg::ACT_MUL_CE_SA: p1_in  = mul_p[31:0];
         ocu_pkg::ACT_MUL_CE_CA: p2_in  = mul_p[31:0];
         ocu_pkg::ACT_MUL_R_SE:  pyp_in = mul_p[43:0];
         ocu_pkg::ACT_MUL_SE_SA: uxp_in = mul_p[30:0];
         ocu_pkg::ACT_MUL_SE_CA: uzp_in = mul_p[30:0];
         ocu_pkg::ACT_MUL_R_P1:  pxp_in = mul_p[58:0];
         ocu_pkg::ACT_MUL_R_P2:  pzp_in = mul_p[58:0];
         default: begin
            az_in = az_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         az_ff  <= '0;
         el_ff  <= '0;
         rad_ff <= 28'(ocu_pkg::RADIUS_RESET);
      end else begin
         az_ff  <= az_in;
         el_ff  <= el_in;
         rad_ff <= rad_in;
      end
   end

   always_ff @(posedge clock) begin
      taz_ff  <= taz_in;
      tel_ff  <= tel_in;
      trad_ff <= trad_in;
      sa_ff   <= sa_in;
      ca_ff   <= ca_in;
      se_ff   <= se_in;
      ce_ff   <= ce_in;
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      pxp_ff  <= pxp_in;
      pyp_ff  <= pyp_in;
      pzp_ff  <= pzp_in;
      uxp_ff  <= uxp_in;
      uzp_ff  <= uzp_in;
   end

   assign cor_angle = (ctrl.act == ocu_pkg::ACT_START_EL) ? 18'(el_ff) :
                      signed'({1'b0, az_ff});

   // round half up; sums wrap harmlessly above the kept bits
   assign px_sum = pxp_ff + 59'(2**29);
   assign pz_sum = pzp_ff + 59'(2**29);
   assign py_sum = pyp_ff + 44'(2**14);
   assign ux_sum = 31'(2**14) - uxp_ff;
   assign uz_sum = 31'(2**14) - uzp_ff;

   // output register frees the sequencer once the result is parked
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_load     = (ctrl.act == ocu_pkg::ACT_EMIT) && out_free;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         pos_x_ff   <= signed'(px_sum[58:30]);
         pos_y_ff   <= signed'(py_sum[43:15]);
         pos_z_ff   <= signed'(pz_sum[58:30]);
         right_x_ff <= -ca_ff;
         right_z_ff <= sa_ff;
         up_x_ff    <= signed'(ux_sum[30:15]);
         up_y_ff    <= ce_ff;
         up_z_ff    <= signed'(uz_sum[30:15]);
         az_now_ff  <= az_ff;
         el_now_ff  <= el_ff;
         rad_now_ff <= rad_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_position_x    = pos_x_ff;
   assign rsp_position_y    = pos_y_ff;
   assign rsp_position_z    = pos_z_ff;
   assign rsp_right_x       = right_x_ff;
   assign rsp_right_y       = 1'b0;
   assign rsp_right_z       = right_z_ff;
   assign rsp_up_x          = up_x_ff;
   assign rsp_up_y          = up_y_ff;
   assign rsp_up_z          = up_z_ff;
   assign rsp_azimuth_now   = az_now_ff;
   assign rsp_elevation_now = el_now_ff;
   assign rsp_radius_now    = rad_now_ff;

endmodule

`default_nettype wire

// ===== rtl/orbit_camera_update_top.sv =====
`default_nettype none

// Orbit camera around the origin: keeps azimuth, elevation and radius, applies one
// rotate, zoom or set-angles request at a time and returns the camera position, right
// and up vectors together with the new state. A microprogram of 19 steps runs a shared
// adder/clamp unit, a CORDIC unit doing one iteration per cycle, and one 32x32
// multiplier; most of a request's time goes to the two CORDIC passes (azimuth, then
// elevation). The result sits in an output register, so the block takes the next
// request while it waits. CSR writes (elevation limit, minimum radius) are accepted
// every cycle and should only be issued while no request is in flight.
module orbit_camera_update_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic signed [17:0]                  req_azimuth_value,
   input  logic signed [17:0]                  req_elevation_value,
   input  logic signed [28:0]                  req_radius_delta,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [28:0]                  rsp_position_x,
   output logic signed [28:0]                  rsp_position_y,
   output logic signed [28:0]                  rsp_position_z,
   output logic signed [15:0]                  rsp_right_x,
   output logic                                rsp_right_y,
   output logic signed [15:0]                  rsp_right_z,
   output logic signed [15:0]                  rsp_up_x,
   output logic signed [15:0]                  rsp_up_y,
   output logic signed [15:0]                  rsp_up_z,
   output logic [16:0]                         rsp_azimuth_now,
   output logic signed [15:0]                  rsp_elevation_now,
   output logic [27:0]                         rsp_radius_now,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ocu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ocu_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic [14:0]        elev_limit_ff, elev_limit_in, elev_lim_eff;
   logic [15:0]        min_radius_ff, min_radius_in, min_rad_eff;
   logic [1:0]         op_ff, op_in;
   logic signed [17:0] az_val_ff, az_val_in, el_val_ff, el_val_in;
   logic signed [28:0] rad_dlt_ff, rad_dlt_in;
   logic               req_fire, out_free, cor_last;
   logic signed [17:0] cor_angle;
   logic signed [15:0] cor_sin, cor_cos;
   ocu_pkg::ctrl_type  ctrl;
   ocu_pkg::stat_type  stat;

   // csr registers
   assign csr_ready = 1'b1;

   always_comb begin
      elev_limit_in = elev_limit_ff;
      min_radius_in = min_radius_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ocu_pkg::CSR_ELEV_LIMIT: elev_limit_in = csr_wdata[14:0];
            ocu_pkg::CSR_MIN_RADIUS: min_radius_in = csr_wdata[15:0];
            default:                 elev_limit_in = elev_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elev_limit_ff <= 15'(ocu_pkg::ELEV_LIMIT_RESET);
         min_radius_ff <= 16'(ocu_pkg::MIN_RADIUS_RESET);
      end else begin
         elev_limit_ff <= elev_limit_in;
         min_radius_ff <= min_radius_in;
      end
   end

   assign elev_lim_eff = (elev_limit_ff > 15'(ocu_pkg::ELEV_CAP)) ?
                         15'(ocu_pkg::ELEV_CAP) : elev_limit_ff;
   assign min_rad_eff  = (min_radius_ff == '0) ? 16'd1 : min_radius_ff;

   // request capture
   assign req_ready = (ctrl.act == ocu_pkg::ACT_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      op_in      = req_fire ? req_operation       : op_ff;
      az_val_in  = req_fire ? req_azimuth_value   : az_val_ff;
      el_val_in  = req_fire ? req_elevation_value : el_val_ff;
      rad_dlt_in = req_fire ? req_radius_delta    : rad_dlt_ff;
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      az_val_ff  <= az_val_in;
      el_val_ff  <= el_val_in;
      rad_dlt_ff <= rad_dlt_in;
   end

   assign stat = '{req_fire: req_fire, out_free: out_free, iter_last: cor_last};

   ocu_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   ocu_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   ((ctrl.act == ocu_pkg::ACT_START_AZ) || (ctrl.act == ocu_pkg::ACT_START_EL)),
      .step    (ctrl.act == ocu_pkg::ACT_ITER),
      .angle   (cor_angle),
      .sin_q15 (cor_sin),
      .cos_q15 (cor_cos),
      .last    (cor_last)
   );

   ocu_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .op                (op_ff),
      .az_value          (az_val_ff),
      .el_value          (el_val_ff),
      .rad_delta         (rad_dlt_ff),
      .elev_lim          (elev_lim_eff),
      .min_rad           (min_rad_eff),
      .cor_sin           (cor_sin),
      .cor_cos           (cor_cos),
      .cor_angle         (cor_angle),
      .out_free          (out_free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_position_x    (rsp_position_x),
      .rsp_position_y    (rsp_position_y),
      .rsp_position_z    (rsp_position_z),
      .rsp_right_x       (rsp_right_x),
      .rsp_right_y       (rsp_right_y),
      .rsp_right_z       (rsp_right_z),
      .rsp_up_x          (rsp_up_x),
      .rsp_up_y          (rsp_up_y),
      .rsp_up_z          (rsp_up_z),
      .rsp_azimuth_now   (rsp_azimuth_now),
      .rsp_elevation_now (rsp_elevation_now),
      .rsp_radius_now    (rsp_radius_now)
   );

endmodule

`default_nettype wire

// ===== rtl/ocu_checker.sv =====
`default_nettype none

module ocu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [28:0] rsp_position_x,
   input logic [16:0]        rsp_azimuth_now,
   input logic signed [15:0] rsp_elevation_now,
   input logic [27:0]        rsp_radius_now
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position_x) &&
                                  $stable(rsp_azimuth_now))
      else $error("result changed while stalled");

   // one request in flight at a time
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // azimuth wrapped, radius never zero
   a_state_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_azimuth_now < 17'd92160) && (rsp_radius_now != 28'd0))
      else $error("azimuth or radius out of range");

   // elevation within the hard cap
   a_elev_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_elevation_now <= 16'sd23039) &&
                    (rsp_elevation_now >= -16'sd23039))
      else $error("elevation beyond cap");

endmodule

bind orbit_camera_update_top ocu_checker u_ocu_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import ocu_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_B = 2'd3;
   localparam int     SETTLE_CYCLES = 2 * CORDIC_N + 24;
   localparam longint LIMIT_CYCLES = 1_000_000;
   localparam longint ROUND_Q30 = 64'sd536870912;
   localparam int     ANGLE_MAX = 92159;
   localparam int     DELTA_MAX = 268435455;

   typedef struct {
      logic signed [28:0] pos_x;
      logic signed [28:0] pos_y;
      logic signed [28:0] pos_z;
      logic signed [15:0] right_x;
      logic               right_y;
      logic signed [15:0] right_z;
      logic signed [15:0] up_x;
      logic signed [15:0] up_y;
      logic signed [15:0] up_z;
      logic [16:0]        azimuth;
      logic signed [15:0] elevation;
      logic [27:0]        radius;
   } camera_pose_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_operation = OP_ROTATE;
   logic signed [17:0]         req_azimuth_value = '0;
   logic signed [17:0]         req_elevation_value = '0;
   logic signed [28:0]         req_radius_delta = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [28:0]         rsp_position_x;
   logic signed [28:0]         rsp_position_y;
   logic signed [28:0]         rsp_position_z;
   logic signed [15:0]         rsp_right_x;
   logic                       rsp_right_y;
   logic signed [15:0]         rsp_right_z;
   logic signed [15:0]         rsp_up_x;
   logic signed [15:0]         rsp_up_y;
   logic signed [15:0]         rsp_up_z;
   logic [16:0]                rsp_azimuth_now;
   logic signed [15:0]         rsp_elevation_now;
   logic [27:0]                rsp_radius_now;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_ELEV_LIMIT;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // camera state and register copies kept by the predictor
   longint cam_azimuth = 0;
   longint cam_elevation = 0;
   longint cam_radius = RADIUS_RESET;
   int     elev_limit_reg = ELEV_LIMIT_RESET;
   int     min_radius_reg = MIN_RADIUS_RESET;

   camera_pose_t pose_queue[$];
   camera_pose_t expected_pose;

   int     mismatch_count = 0;
   int     responses_checked = 0;
   int     op_counts[4] = '{0, 0, 0, 0};
   int     elevation_clamps = 0;
   int     radius_floors = 0;
   int     radius_tops = 0;
   int     azimuth_wraps = 0;
   int     register_writes = 0;
   longint cycle_count = 0;

   int burst_left = 0;

   int ready_mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit stalled = 1'b0;
   bit ready_next = 1'b1;

   orbit_camera_update_top u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_azimuth_value   (req_azimuth_value),
      .req_elevation_value (req_elevation_value),
      .req_radius_delta    (req_radius_delta),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_position_x      (rsp_position_x),
      .rsp_position_y      (rsp_position_y),
      .rsp_position_z      (rsp_position_z),
      .rsp_right_x         (rsp_right_x),
      .rsp_right_y         (rsp_right_y),
      .rsp_right_z         (rsp_right_z),
      .rsp_up_x            (rsp_up_x),
      .rsp_up_y            (rsp_up_y),
      .rsp_up_z            (rsp_up_z),
      .rsp_azimuth_now     (rsp_azimuth_now),
      .rsp_elevation_now   (rsp_elevation_now),
      .rsp_radius_now      (rsp_radius_now),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint atan_deg_q16(input int i);
      case (i)
         0:  return 2949120;
         1:  return 1740967;
         2:  return 919879;
         3:  return 466945;
         4:  return 234379;
         5:  return 117304;
         6:  return 58666;
         7:  return 29335;
         8:  return 14668;
         9:  return 7334;
         10: return 3667;
         11: return 1833;
         12: return 917;
         13: return 458;
         14: return 229;
         15: return 115;
         16: return 57;
         17: return 29;
         18: return 14;
         19: return 7;
         20: return 4;
         21: return 2;
         22: return 1;
         default: return 0;
      endcase
   endfunction

   function automatic longint round_q15(input longint v);
      longint r;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      if (r < -32767) r = -32767;
      return r;
   endfunction

   function automatic void sin_cos_q15(input longint angle, output longint sin_v,
                                       output longint cos_v);
      longint a, x, y, z, nx;
      bit     flip;
      int     i;
      a = angle % FULL_TURN;
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      if (a > HALF_TURN) a -= FULL_TURN;
      if (a <= -HALF_TURN) a += FULL_TURN;
      // fold into the cordic's convergence range and negate at the end
      if (a > QUARTER_TURN) begin
         a -= HALF_TURN;
         flip = 1'b1;
      end else if (a < -QUARTER_TURN) begin
         a += HALF_TURN;
         flip = 1'b1;
      end
      z = a * 256;
      for (i = 0; i < CORDIC_N; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= atan_deg_q16(i);
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += atan_deg_q16(i);
         end
         x = nx;
      end
      cos_v = round_q15(x);
      sin_v = round_q15(y);
      if (flip) begin
         cos_v = -cos_v;
         sin_v = -sin_v;
      end
   endfunction

   function automatic longint wrap_turn(input longint a);
      longint w;
      w = a % FULL_TURN;
      if (w < 0) w += FULL_TURN;
      if (w != a) azimuth_wraps++;
      return w;
   endfunction

   function automatic longint clamp_elevation(input longint e);
      longint lim;
      lim = (elev_limit_reg > ELEV_CAP) ? ELEV_CAP : elev_limit_reg;
      if (e > lim || e < -lim) elevation_clamps++;
      if (e > lim) e = lim;
      if (e < -lim) e = -lim;
      return e;
   endfunction

   function automatic camera_pose_t advance_camera(input logic [1:0] op, input int av,
                                                   input int ev, input int rd);
      longint       sa, ca, se, ce, minr, r;
      camera_pose_t p;
      op_counts[op]++;
      case (op)
         OP_ROTATE: begin
            cam_azimuth   = wrap_turn(cam_azimuth + av);
            cam_elevation = clamp_elevation(cam_elevation + ev);
         end
         OP_ZOOM: begin
            minr = (min_radius_reg == 0) ? 1 : min_radius_reg;
            r = cam_radius - rd;
            if (r < minr) begin
               r = minr;
               radius_floors++;
            end
            if (r > RADIUS_MAX) begin
               r = RADIUS_MAX;
               radius_tops++;
            end
            cam_radius = r;
         end
         OP_SET: begin
            cam_azimuth   = wrap_turn(av);
            cam_elevation = clamp_elevation(ev);
         end
         default: ;
      endcase
      sin_cos_q15(cam_azimuth, sa, ca);
      sin_cos_q15(cam_elevation, se, ce);
      p.pos_x     = (cam_radius * ce * sa + ROUND_Q30) >>> 30;
      p.pos_y     = (cam_radius * se + 16384) >>> 15;
      p.pos_z     = (cam_radius * ce * ca + ROUND_Q30) >>> 30;
      p.right_x   = -ca;
      p.right_y   = 1'b0;
      p.right_z   = sa;
      p.up_x      = (-se * sa + 16384) >>> 15;
      p.up_y      = ce;
      p.up_z      = (-se * ca + 16384) >>> 15;
      p.azimuth   = cam_azimuth;
      p.elevation = cam_elevation;
      p.radius    = cam_radius;
      return p;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("%0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic signed [63:0] got,
                              input logic signed [63:0] want);
      if (got !== want)
         report_error($sformatf("response %0d %s: got %0d expected %0d",
                                responses_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pose_queue.size() == 0) begin
            report_error("response with no request outstanding");
         end else begin
            expected_pose = pose_queue.pop_front();
            check_field("position_x", rsp_position_x, expected_pose.pos_x);
            check_field("position_y", rsp_position_y, expected_pose.pos_y);
            check_field("position_z", rsp_position_z, expected_pose.pos_z);
            check_field("right_x", rsp_right_x, expected_pose.right_x);
            check_field("right_y", rsp_right_y, expected_pose.right_y);
            check_field("right_z", rsp_right_z, expected_pose.right_z);
            check_field("up_x", rsp_up_x, expected_pose.up_x);
            check_field("up_y", rsp_up_y, expected_pose.up_y);
            check_field("up_z", rsp_up_z, expected_pose.up_z);
            check_field("azimuth_now", rsp_azimuth_now, expected_pose.azimuth);
            check_field("elevation_now", rsp_elevation_now, expected_pose.elevation);
            check_field("radius_now", rsp_radius_now, expected_pose.radius);
         end
         responses_checked++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pose_queue.size());
         $display("FAIL");
         $finish;
      end
   end

   // response side back-pressure: always ready, coin flips, or long stalls
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 400);
      end
      mode_left--;
      case (ready_mode)
         0: ready_next = 1'b1;
         1: ready_next = $urandom_range(0, 1);
         default: begin
            if (hold_left == 0) begin
               stalled   = !stalled;
               hold_left = stalled ? $urandom_range(1, 40) : $urandom_range(1, 6);
            end
            hold_left--;
            ready_next = !stalled;
         end
      endcase
      rsp_ready <= ready_next;
   end

   // ---------------------------------------------------------------- driving

   task automatic send_request(input logic [1:0] op, input int av, input int ev,
                               input int rd);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock) req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid           <= 1'b1;
      req_operation       <= op;
      req_azimuth_value   <= av;
      req_elevation_value <= ev;
      req_radius_delta    <= rd;
      do @(posedge clock); while (!req_ready);
      pose_queue.push_back(advance_camera(op, av, ev, rd));
   endtask

   // stop sending and let every outstanding response drain
   task automatic quiesce();
      @(negedge clock) req_valid <= 1'b0;
      burst_left = 0;
      while (pose_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_ELEV_LIMIT: elev_limit_reg = data & 16'h7FFF;
         CSR_MIN_RADIUS: min_radius_reg = data;
         default: ;
      endcase
      register_writes++;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic int pick_angle();
      int k;
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1024) - 512;
         1: begin
            // land near a quadrant boundary
            k = $urandom_range(0, 6) - 3;
            return k * QUARTER_TURN + $urandom_range(0, 6) - 3;
         end
         2: return $urandom_range(0, 1) ? $urandom_range(22990, 23100)
                                        : -$urandom_range(22990, 23100);
         3: return $urandom_range(0, 1) ? ANGLE_MAX : -ANGLE_MAX;
         default: return $urandom_range(0, 2 * ANGLE_MAX) - ANGLE_MAX;
      endcase
   endfunction

   function automatic int pick_radius_delta();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 8192) - 4096;
         1: return $urandom_range(0, 2097152) - 1048576;
         2: return $urandom_range(0, 134217728) - 67108864;
         3: return $urandom_range(0, 1) ? DELTA_MAX : -DELTA_MAX;
         default: return $urandom_range(0, 2 * DELTA_MAX) - DELTA_MAX;
      endcase
   endfunction

   task automatic run_random_batch(input int count);
      int          sel;
      logic [1:0]  op;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) op = OP_ROTATE;
         else if (sel < 65) op = OP_ZOOM;
         else if (sel < 95) op = OP_SET;
         else op = OP_UNUSED;
         send_request(op, pick_angle(), pick_angle(), pick_radius_delta());
      end
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_unused_operation();
      // state straight out of reset, then the extremes with no effect
      send_request(OP_UNUSED, -ANGLE_MAX, ANGLE_MAX, -DELTA_MAX);
      send_request(OP_ZOOM, 0, 0, 0);
      send_request(OP_UNUSED, ANGLE_MAX, -ANGLE_MAX, DELTA_MAX);
   endtask

   task automatic test_angle_wrap();
      send_request(OP_ROTATE, ANGLE_MAX, 0, 0);
      send_request(OP_ROTATE, ANGLE_MAX, 0, 0);
      send_request(OP_ROTATE, -ANGLE_MAX, 0, 0);
      send_request(OP_SET, -ANGLE_MAX, 0, 0);
      send_request(OP_SET, ANGLE_MAX, 0, 0);
      send_request(OP_SET, 0, 0, 0);
      send_request(OP_SET, QUARTER_TURN, 0, 0);
      send_request(OP_SET, HALF_TURN, 0, 0);
      send_request(OP_SET, 3 * QUARTER_TURN, 0, 0);
      send_request(OP_SET, -QUARTER_TURN, 0, 0);
      send_request(OP_SET, -HALF_TURN, 0, 0);
   endtask

   task automatic test_elevation_clamp();
      send_request(OP_SET, 1000, ANGLE_MAX, 0);
      send_request(OP_ROTATE, 0, -1, 0);
      send_request(OP_ROTATE, 0, 2, 0);
      send_request(OP_SET, 1000, -ANGLE_MAX, 0);
      send_request(OP_SET, 1000, ELEV_LIMIT_RESET, 0);
   endtask

   task automatic test_zoom_limits();
      send_request(OP_ZOOM, 0, 0, DELTA_MAX);
      send_request(OP_ZOOM, 0, 0, -DELTA_MAX);
      send_request(OP_ZOOM, 0, 0, -1);
      send_request(OP_ZOOM, 0, 0, 0);
   endtask

   task automatic test_register_extremes();
      quiesce();
      write_register(CSR_ELEV_LIMIT, 16'h0000);
      write_register(CSR_MIN_RADIUS, 16'h0000);
      run_random_batch(100);
      quiesce();
      write_register(CSR_ELEV_LIMIT, ELEV_CAP);
      write_register(CSR_MIN_RADIUS, 16'hFFFF);
      run_random_batch(100);
      quiesce();
      // top bit is dropped, the rest is above the hard cap, so the hard cap applies
      write_register(CSR_ELEV_LIMIT, 16'hFFFF);
      write_register(CSR_MIN_RADIUS, 16'h0001);
      write_register(CSR_UNUSED_A, 16'h0000);
      write_register(CSR_UNUSED_B, 16'hFFFF);
      run_random_batch(100);
      quiesce();
      write_register(CSR_ELEV_LIMIT, 16'h0001);
      write_register(CSR_MIN_RADIUS, 16'h8000);
      run_random_batch(100);
      quiesce();
      write_register(CSR_ELEV_LIMIT, ELEV_LIMIT_RESET);
      write_register(CSR_MIN_RADIUS, MIN_RADIUS_RESET);
      run_random_batch(100);
   endtask

   task automatic test_random_traffic();
      int blk;
      for (blk = 0; blk < 6; blk++) begin
         if (blk != 0) begin
            quiesce();
            write_register(CSR_ELEV_LIMIT, $urandom_range(0, 1) ?
                           $urandom_range(20000, 23100) : $urandom_range(0, 32767));
            write_register(CSR_MIN_RADIUS, $urandom_range(0, 65535));
         end
         run_random_batch(200);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
      test_unused_operation();
      test_angle_wrap();
      test_elevation_clamp();
      test_zoom_limits();
      test_register_extremes();
      test_random_traffic();
      quiesce();
      $display("covered %0d requests (%0d rotate, %0d zoom, %0d set, %0d unused op), %0d checked",
               op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3], op_counts[0],
               op_counts[1], op_counts[2], op_counts[3], responses_checked);
      $display("elevation clamps %0d, radius floors %0d, radius tops %0d, wraps %0d, csr writes %0d",
               elevation_clamps, radius_floors, radius_tops, azimuth_wraps, register_writes);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
